// ===== rtl/brf_pkg.sv =====
// Package: shared types, codes and helpers for the byte ring with scan.
`default_nettype none

package brf_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int BYTE_W         = 8;
    localparam int VALUE_W        = 32;

    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP8   = 3'd1,
        ACT_POP16  = 3'd2,
        ACT_POP32  = 3'd3,
        ACT_PEEK   = 3'd4,
        ACT_FLUSH  = 3'd5,
        ACT_SEARCH = 3'd6
    } act_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_SHORT = 2'd1,
        STS_FULL  = 2'd2
    } sts_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctl_t;

    function automatic logic [2:0] want_bytes(input act_t act);
        logic [2:0] n;
        case (act)
            ACT_POP16: n = 3'd2;
            ACT_POP32: n = 3'd4;
            default:   n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic is_line_end(input logic [7:0] b);
        return (b == BYTE_LF) || (b == BYTE_CR);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/brf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/brf_scan.sv =====
// Search unit: per-byte match test and running hit count.
`default_nettype none

module brf_scan #(
    parameter int RING_DEPTH = brf_pkg::RING_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire brf_pkg::scan_ctl_t ctl,
    input  wire logic [7:0]        data,
    input  wire logic [7:0]        key,
    input  wire logic [7:0]        need,
    output logic                   hit
);
    import brf_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = (AW > 8) ? AW : 8;

    logic [AW-1:0] hits_reg;
    logic [AW-1:0] hits_next;

    assign hits_next = hits_reg + AW'(data == key);
    assign hit = (is_line_end(data) && is_line_end(key))
               || (CW'(hits_next) == CW'(need));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg <= '0;
        end
        else if (ctl.clear)
        begin
            hits_reg <= '0;
        end
        else if (ctl.step)
        begin
            hits_reg <= hits_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/byte_ring_fifo_with_scan.sv =====
// Top level: byte ring with push, pop, peek, flush and search sequencer.
//
//  channel   | signals                                         | transfer
//  ----------+-------------------------------------------------+------------------------
//  command   | start, busy, action, push_byte, search_byte,    | start && !busy
//            | search_count                                    |
//  result    | done, status, read_value, found, stored_count   | done (one cycle)
//
//  Push, flush, unused codes, refused pops/peeks and searches of an empty ring: done in
//  the cycle after the transfer.
//  Pop of n bytes or peek (n = 1): reads stream one byte a cycle from the single RAM
//  read port with registered read data and are shifted into read_value; done follows
//  the last byte.
//  Search: the stored bytes stream through the scan unit in ring order; done after the
//  last stored byte, earlier at the first hit.
//  Reset empties the ring at once; the byte store itself is not cleared.
//  The receiver cannot stall; busy stays high until the cycle after done.
`default_nettype none

module byte_ring_fifo_with_scan #(
    parameter int RING_DEPTH = brf_pkg::RING_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  action,
    input  wire logic [7:0]  push_byte,
    input  wire logic [7:0]  search_byte,
    input  wire logic [7:0]  search_count,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      read_value,
    output logic             found,
    output logic [7:0]       stored_count
);
    import brf_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    state_t              state_reg, state_next;
    act_t                act_reg, act_next;
    logic [7:0]          key_reg, key_next;
    logic [7:0]          need_reg, need_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic [AW-1:0]       wr_idx_reg, wr_idx_next;
    logic [AW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       iss_left_reg, iss_left_next;
    logic [AW-1:0]       take_left_reg, take_left_next;
    logic                vld_reg, vld_next;
    sts_t                status_reg, status_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic                found_reg, found_next;

    logic                ram_we;
    logic                ram_re;
    logic [BYTE_W-1:0]   ram_rdata;
    scan_ctl_t           scan_ctl;
    logic                scan_hit;
    logic [AW-1:0]       want;

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (push_byte),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    brf_scan #(
        .RING_DEPTH (RING_DEPTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .data  (ram_rdata),
        .key   (key_reg),
        .need  (need_reg),
        .hit   (scan_hit)
    );

    assign want = AW'(want_bytes(act_t'(action)));

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        need_next      = need_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        iss_left_next  = iss_left_reg;
        take_left_next = take_left_reg;
        vld_next       = 1'b0;
        status_next    = status_reg;
        value_next     = value_reg;
        found_next     = found_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        scan_ctl       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next       = act_t'(action);
                    key_next       = search_byte;
                    need_next      = search_count;
                    status_next    = STS_OK;
                    value_next     = '0;
                    found_next     = 1'b0;
                    ptr_next       = rd_idx_reg;
                    scan_ctl.clear = 1'b1;
                    state_next     = S_DONE;
                    case (act_t'(action))
                        ACT_PUSH:
                        begin
                            if (fill_reg != LAST_IDX)
                            begin
                                ram_we      = 1'b1;
                                wr_idx_next = ring_next(wr_idx_reg);
                                fill_next   = fill_reg + AW'(1);
                            end
                            else
                            begin
                                status_next = STS_FULL;
                            end
                        end
                        ACT_POP8, ACT_POP16, ACT_POP32, ACT_PEEK:
                        begin
                            if (fill_reg < want)
                            begin
                                status_next = STS_SHORT;
                            end
                            else
                            begin
                                iss_left_next  = want;
                                take_left_next = want;
                                state_next     = S_READ;
                            end
                        end
                        ACT_FLUSH:
                        begin
                            rd_idx_next = '0;
                            wr_idx_next = '0;
                            fill_next   = '0;
                        end
                        ACT_SEARCH:
                        begin
                            if (fill_reg != '0)
                            begin
                                iss_left_next  = fill_reg;
                                take_left_next = fill_reg;
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (iss_left_reg != '0)
                begin
                    ram_re        = 1'b1;
                    ptr_next      = ring_next(ptr_reg);
                    iss_left_next = iss_left_reg - AW'(1);
                    vld_next      = 1'b1;
                end
                if (vld_reg)
                begin
                    take_left_next = take_left_reg - AW'(1);
                    if (act_reg == ACT_SEARCH)
                    begin
                        scan_ctl.step = 1'b1;
                        if (scan_hit)
                        begin
                            found_next = 1'b1;
                            state_next = S_DONE;
                        end
                        else if (take_left_reg == AW'(1))
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        value_next = {value_reg[VALUE_W-BYTE_W-1:0], ram_rdata};
                        if (take_left_reg == AW'(1))
                        begin
                            state_next = S_DONE;
                            if (act_reg != ACT_PEEK)
                            begin
                                rd_idx_next = ptr_reg;
                                fill_next   = fill_reg - AW'(want_bytes(act_reg));
                            end
                        end
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            fill_reg   <= '0;
            vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            fill_reg   <= fill_next;
            vld_reg    <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        need_reg      <= need_next;
        ptr_reg       <= ptr_next;
        iss_left_reg  <= iss_left_next;
        take_left_reg <= take_left_next;
        status_reg    <= status_next;
        value_reg     <= value_next;
        found_reg     <= found_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign status       = status_reg;
    assign read_value   = value_reg;
    assign found        = found_reg;
    assign stored_count = 8'(fill_reg);

endmodule

`default_nettype wire

// ===== rtl/brf_chk.sv =====
// Port-level checker for the byte ring with scan, bound to the top level.
`default_nettype none

module brf_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [31:0] read_value,
    input wire logic        found
);
    import brf_pkg::*;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done held longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STS_SHORT || status == STS_FULL) |->
            read_value == 32'd0 && !found)
        else $error("refused action carries data");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> status == STS_OK && read_value == 32'd0)
        else $error("search hit with bad status or data");

endmodule

bind byte_ring_fifo_with_scan brf_chk u_brf_chk (.*);

`default_nettype wire
